@@ src/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked while out of reset.
`define PVME_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvme assertion failed");

// Checked at every edge, reset included.
`define PVME_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pvme assertion failed");

`else

`define PVME_ASSERT(lbl, clk, rst_n, prop)
`define PVME_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ src/pvme_pkg.sv @@
`timescale 1ns / 1ps

package pvme_pkg;

    // Q30 fixed point
    localparam logic [32:0] ONE_Q30  = 33'd1073741824;
    localparam logic [65:0] HALF_Q30 = 66'd536870912;

    // Polynomial cross-term weights, Q30
    localparam logic [32:0] K_G4L  = 33'd2891253872;
    localparam logic [32:0] K_G3L2 = 33'd2607506858;
    localparam logic [32:0] K_G2L3 = 33'd4801376152;
    localparam logic [32:0] K_GL4  = 33'd84202834;

    // Mixing fraction polynomial, Q30
    localparam logic [32:0] E_LIN = 33'd1466763544;
    localparam logic [32:0] E_SQ  = 33'd512378861;
    localparam logic [32:0] E_CUB = 33'd119357141;

    // Ratio saturation (2.0 in Q30)
    localparam logic [31:0] R_MAX = 32'h8000_0000;
    localparam logic [16:0] ETA_MAX = 17'd65536;

    // Chain lengths
    localparam int DIV_A_CELLS = 31;
    localparam int DIV_R_CELLS = 32;
    localparam int ROOT_CELLS  = 31;

    // Data riding along the divider chain
    typedef struct packed {
        logic        zero;
        logic        flag_a;
        logic        flag_b;
        logic [32:0] val;
    } t_dside;

    // Data riding along the root chain
    typedef struct packed {
        logic        zero;
        logic [32:0] s;
        logic [30:0] a;
    } t_rside;

    // Q30 multiply, rounding half up
    function automatic logic [35:0] qmul(input logic [32:0] x, input logic [32:0] y);
        logic [65:0] p;
        begin
            p = 66'(x) * 66'(y) + HALF_Q30;
            return p[65:30];
        end
    endfunction

endpackage

@@ src/pseudo_voigt_mixing_eta.sv @@
`timescale 1ns / 1ps

// Pseudo-Voigt mixing fraction and combined width. Fully pipelined: a new
// width pair is taken on every cycle with start high (busy is always low),
// and its result appears on o_valid for one cycle at the end of the pipeline;
// the receiver cannot stall and must take every beat. The pipeline is made of
// the cell chains: 31 cells for the width-fraction divide, 6 polynomial
// stages, 31 three-stage fifth-root cells, 32 cells for the ratio divide,
// 6 stages for eta, plus two boundary registers.
`include "assert_macros.svh"

module pseudo_voigt_mixing_eta (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_lorentz_width,
    input  logic [31:0] i_gauss_width,
    output logic        o_valid,
    output logic [16:0] o_mixing_fraction,
    output logic [32:0] o_combined_width,
    output logic        o_zero_width
);
    import pvme_pkg::*;

    // divider chain A: a = round(L * 2^30 / (L + G))
    logic        da_v    [0:DIV_A_CELLS];
    logic [32:0] da_rem  [0:DIV_A_CELLS];
    logic [32:0] da_div  [0:DIV_A_CELLS];
    logic [31:0] da_tail [0:DIV_A_CELLS];
    logic [31:0] da_quo  [0:DIV_A_CELLS];
    t_dside      da_side [0:DIV_A_CELLS];

    // root chain
    logic        rt_v    [0:ROOT_CELLS];
    logic [30:0] rt_p    [0:ROOT_CELLS];
    logic [30:0] rt_y    [0:ROOT_CELLS];
    logic [30:0] rt_m    [0:ROOT_CELLS];
    t_rside      rt_side [0:ROOT_CELLS];

    // divider chain R: r = floor(a * 2^30 / y)
    logic        dr_v    [0:DIV_R_CELLS];
    logic [32:0] dr_rem  [0:DIV_R_CELLS];
    logic [32:0] dr_div  [0:DIV_R_CELLS];
    logic [31:0] dr_tail [0:DIV_R_CELLS];
    logic [31:0] dr_quo  [0:DIV_R_CELLS];
    t_dside      dr_side [0:DIV_R_CELLS];

    logic [32:0] n_sum;
    logic [62:0] n_num;
    logic        r_in_v;
    logic        r_mid_v;
    t_rside      fin;

    assign busy = 1'b0;

    // input beat: sum of widths and rounded numerator
    assign n_sum = 33'(i_lorentz_width) + 33'(i_gauss_width);
    assign n_num = {i_lorentz_width, 30'd0} + 63'(n_sum[32:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_mid_v <= 1'b0;
        end else begin
            r_in_v  <= start && !busy;
            r_mid_v <= rt_v[ROOT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        da_rem[0]         <= 33'(n_num[62:31]);
        da_div[0]         <= n_sum;
        da_tail[0]        <= {n_num[30:0], 1'b0};
        da_quo[0]         <= '0;
        da_side[0].zero   <= (n_sum == '0);
        da_side[0].flag_a <= 1'b0;
        da_side[0].flag_b <= 1'b0;
        da_side[0].val    <= n_sum;
    end
    assign da_v[0] = r_in_v;

    for (genvar g = 0; g < DIV_A_CELLS; g++) begin : g_div_a
        pvme_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (da_v[g]),
            .i_rem   (da_rem[g]),
            .i_div   (da_div[g]),
            .i_tail  (da_tail[g]),
            .i_quo   (da_quo[g]),
            .i_side  (da_side[g]),
            .o_valid (da_v[g+1]),
            .o_rem   (da_rem[g+1]),
            .o_div   (da_div[g+1]),
            .o_tail  (da_tail[g+1]),
            .o_quo   (da_quo[g+1]),
            .o_side  (da_side[g+1])
        );
    end

    // powers and weighted polynomial
    pvme_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (da_v[DIV_A_CELLS]),
        .i_quo   (da_quo[DIV_A_CELLS]),
        .i_side  (da_side[DIV_A_CELLS]),
        .o_valid (rt_v[0]),
        .o_p     (rt_p[0]),
        .o_rside (rt_side[0])
    );
    assign rt_y[0] = '0;
    assign rt_m[0] = 31'(ONE_Q30);

    // fifth root, one bit per cell, MSB first
    for (genvar g = 0; g < ROOT_CELLS; g++) begin : g_root
        pvme_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (rt_v[g]),
            .i_p     (rt_p[g]),
            .i_y     (rt_y[g]),
            .i_m     (rt_m[g]),
            .i_side  (rt_side[g]),
            .o_valid (rt_v[g+1]),
            .o_p     (rt_p[g+1]),
            .o_y     (rt_y[g+1]),
            .o_m     (rt_m[g+1]),
            .o_side  (rt_side[g+1])
        );
    end

    // combined width and ratio divide setup
    assign fin = rt_side[ROOT_CELLS];

    always_ff @(posedge i_clk) begin
        dr_rem[0]         <= 33'(fin.a[30:2]);
        dr_div[0]         <= 33'(rt_y[ROOT_CELLS]);
        dr_tail[0]        <= {fin.a[1:0], 30'd0};
        dr_quo[0]         <= '0;
        dr_side[0].zero   <= fin.zero;
        dr_side[0].flag_a <= (rt_y[ROOT_CELLS] == '0);
        dr_side[0].flag_b <= (fin.a[30:2] >= 29'(rt_y[ROOT_CELLS] >> 2))
                             && (31'(fin.a[30:2]) >= rt_y[ROOT_CELLS]);
        dr_side[0].val    <= 33'(qmul(fin.s, 33'(rt_y[ROOT_CELLS])));
    end
    assign dr_v[0] = r_mid_v;

    for (genvar g = 0; g < DIV_R_CELLS; g++) begin : g_div_r
        pvme_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dr_v[g]),
            .i_rem   (dr_rem[g]),
            .i_div   (dr_div[g]),
            .i_tail  (dr_tail[g]),
            .i_quo   (dr_quo[g]),
            .i_side  (dr_side[g]),
            .o_valid (dr_v[g+1]),
            .o_rem   (dr_rem[g+1]),
            .o_div   (dr_div[g+1]),
            .o_tail  (dr_tail[g+1]),
            .o_quo   (dr_quo[g+1]),
            .o_side  (dr_side[g+1])
        );
    end

    // mixing fraction
    pvme_eta u_eta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dr_v[DIV_R_CELLS]),
        .i_quo   (dr_quo[DIV_R_CELLS]),
        .i_side  (dr_side[DIV_R_CELLS]),
        .o_valid (o_valid),
        .o_eta   (o_mixing_fraction),
        .o_width (o_combined_width),
        .o_zero  (o_zero_width)
    );

    // checks
    `PVME_ASSERT_ALWAYS(a_rst_clears_strobe, i_clk, !i_rst_n |=> !o_valid)
    `PVME_ASSERT(a_zero_forces_outputs, i_clk, i_rst_n, o_valid && o_zero_width |-> o_mixing_fraction == '0 && o_combined_width == '0)
    `PVME_ASSERT(a_eta_in_range, i_clk, i_rst_n, o_valid |-> o_mixing_fraction <= ETA_MAX)

endmodule

@@ src/pvme_div_cell.sv @@
`timescale 1ns / 1ps

// One restoring-division step: one quotient bit per cell.
module pvme_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [32:0]          i_rem,
    input  logic [32:0]          i_div,
    input  logic [31:0]          i_tail,
    input  logic [31:0]          i_quo,
    input  pvme_pkg::t_dside     i_side,
    output logic                 o_valid,
    output logic [32:0]          o_rem,
    output logic [32:0]          o_div,
    output logic [31:0]          o_tail,
    output logic [31:0]          o_quo,
    output pvme_pkg::t_dside     o_side
);
    import pvme_pkg::*;

    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;

    // shift in next numerator bit, trial subtract
    always_comb begin
        trial = {i_rem, i_tail[31]};
        diff  = trial - {1'b0, i_div};
        ge    = (trial >= {1'b0, i_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rem  <= ge ? diff[32:0] : trial[32:0];
        o_div  <= i_div;
        o_tail <= {i_tail[30:0], 1'b0};
        o_quo  <= {i_quo[30:0], ge};
        o_side <= i_side;
    end

endmodule

@@ src/pvme_poly.sv @@
`timescale 1ns / 1ps

// Width fractions a, b, their powers and the weighted degree-five sum.
// Six register stages.
module pvme_poly (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_quo,
    input  pvme_pkg::t_dside     i_side,
    output logic                 o_valid,
    output logic [30:0]          o_p,
    output pvme_pkg::t_rside     o_rside
);
    import pvme_pkg::*;

    logic [5:0]  r_v;
    t_rside      r1_rs, r2_rs, r3_rs, r4_rs, r5_rs;
    logic [30:0] r1_b;
    logic [30:0] r2_a2, r2_b2, r2_b;
    logic [30:0] r3_a2, r3_a3, r3_a4, r3_b, r3_b2, r3_b3, r3_b4;
    logic [30:0] r4_a2, r4_a3, r4_a4, r4_a5, r4_b5;
    logic [32:0] r4_m1, r4_m2, r4_m3, r4_m4;
    logic [30:0] r5_a5, r5_b5;
    logic [32:0] r5_t1, r5_t2, r5_t3, r5_t4;
    logic [30:0] n_a;
    logic [35:0] sum;

    // clamp quotient to 1.0
    assign n_a = (i_quo > 32'(ONE_Q30)) ? ONE_Q30[30:0] : i_quo[30:0];

    assign sum = 36'(r5_b5) + 36'(r5_t1) + 36'(r5_t2) + 36'(r5_t3)
               + 36'(r5_t4) + 36'(r5_a5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: fractions
        r1_rs.zero <= i_side.zero;
        r1_rs.s    <= i_side.val;
        r1_rs.a    <= n_a;
        r1_b       <= 31'(ONE_Q30) - n_a;
        // stage 2: squares
        r2_rs <= r1_rs;
        r2_b  <= r1_b;
        r2_a2 <= 31'(qmul(33'(r1_rs.a), 33'(r1_rs.a)));
        r2_b2 <= 31'(qmul(33'(r1_b), 33'(r1_b)));
        // stage 3: cubes and fourth powers
        r3_rs <= r2_rs;
        r3_a2 <= r2_a2;
        r3_b  <= r2_b;
        r3_b2 <= r2_b2;
        r3_a3 <= 31'(qmul(33'(r2_a2), 33'(r2_rs.a)));
        r3_a4 <= 31'(qmul(33'(r2_a2), 33'(r2_a2)));
        r3_b3 <= 31'(qmul(33'(r2_b2), 33'(r2_b)));
        r3_b4 <= 31'(qmul(33'(r2_b2), 33'(r2_b2)));
        // stage 4: fifth powers, weighted b powers
        r4_rs <= r3_rs;
        r4_a2 <= r3_a2;
        r4_a3 <= r3_a3;
        r4_a4 <= r3_a4;
        r4_a5 <= 31'(qmul(33'(r3_a4), 33'(r3_rs.a)));
        r4_b5 <= 31'(qmul(33'(r3_b4), 33'(r3_b)));
        r4_m1 <= 33'(qmul(K_G4L, 33'(r3_b4)));
        r4_m2 <= 33'(qmul(K_G3L2, 33'(r3_b3)));
        r4_m3 <= 33'(qmul(K_G2L3, 33'(r3_b2)));
        r4_m4 <= 33'(qmul(K_GL4, 33'(r3_b)));
        // stage 5: cross terms
        r5_rs <= r4_rs;
        r5_a5 <= r4_a5;
        r5_b5 <= r4_b5;
        r5_t1 <= 33'(qmul(r4_m1, 33'(r4_rs.a)));
        r5_t2 <= 33'(qmul(r4_m2, 33'(r4_a2)));
        r5_t3 <= 33'(qmul(r4_m3, 33'(r4_a3)));
        r5_t4 <= 33'(qmul(r4_m4, 33'(r4_a4)));
        // stage 6: sum, saturate to 1.0
        o_rside <= r5_rs;
        o_p     <= (sum > 36'(ONE_Q30)) ? ONE_Q30[30:0] : sum[30:0];
    end

    assign o_valid = r_v[5];

endmodule

@@ src/pvme_root_cell.sv @@
`timescale 1ns / 1ps

// One bit of the fifth-root search: try y | m, keep it if cand <= 1.0 and cand^5 <= P.
// Three register stages (square, fourth power, fifth power and decide).
module pvme_root_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [30:0]          i_p,
    input  logic [30:0]          i_y,
    input  logic [30:0]          i_m,
    input  pvme_pkg::t_rside     i_side,
    output logic                 o_valid,
    output logic [30:0]          o_p,
    output logic [30:0]          o_y,
    output logic [30:0]          o_m,
    output pvme_pkg::t_rside     o_side
);
    import pvme_pkg::*;

    logic [2:0]  r_v;
    logic [30:0] n_cand;
    logic [30:0] r1_cand, r1_y2, r1_y, r1_m, r1_p;
    logic [30:0] r2_cand, r2_y4, r2_y, r2_m, r2_p;
    logic        r1_ok, r2_ok;
    t_rside      r1_side, r2_side;
    logic [30:0] y5;
    logic        take;

    assign n_cand = i_y | i_m;
    assign y5     = 31'(qmul(33'(r2_y4), 33'(r2_cand)));
    assign take   = r2_ok && (y5 <= r2_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // square
        r1_cand <= n_cand;
        r1_ok   <= (33'(n_cand) <= ONE_Q30);
        r1_y2   <= 31'(qmul(33'(n_cand), 33'(n_cand)));
        r1_y    <= i_y;
        r1_m    <= i_m;
        r1_p    <= i_p;
        r1_side <= i_side;
        // fourth power
        r2_cand <= r1_cand;
        r2_ok   <= r1_ok;
        r2_y4   <= 31'(qmul(33'(r1_y2), 33'(r1_y2)));
        r2_y    <= r1_y;
        r2_m    <= r1_m;
        r2_p    <= r1_p;
        r2_side <= r1_side;
        // fifth power, keep or drop the bit
        o_y    <= take ? r2_cand : r2_y;
        o_m    <= r2_m >> 1;
        o_p    <= r2_p;
        o_side <= r2_side;
    end

    assign o_valid = r_v[2];

endmodule

@@ src/pvme_eta.sv @@
`timescale 1ns / 1ps

// Ratio saturation and eta = r*(E1 - E2 r + E3 r^2). Six register stages.
module pvme_eta (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [31:0]          i_quo,
    input  pvme_pkg::t_dside     i_side,
    output logic                 o_valid,
    output logic [16:0]          o_eta,
    output logic [32:0]          o_width,
    output logic                 o_zero
);
    import pvme_pkg::*;

    // side: flag_a = root was zero, flag_b = quotient overflow, val = width
    logic [5:0]  r_v;
    t_dside      r1_s, r2_s, r3_s, r4_s, r5_s;
    logic [31:0] r1_r, r2_r, r3_r, r4_r;
    logic [32:0] r2_rr, r2_t, r3_t, r3_u;
    logic [32:0] r4_q;
    logic [35:0] r5_e;
    logic [31:0] n_r;
    logic [33:0] lin_sum;
    logic [21:0] eta_rnd;

    always_comb begin
        if (i_side.flag_a) begin
            n_r = '0;
        end else if (i_side.flag_b || i_quo > R_MAX) begin
            n_r = R_MAX;
        end else begin
            n_r = i_quo;
        end
    end

    assign lin_sum = 34'(E_LIN) + 34'(r3_u);
    assign eta_rnd = 22'((r5_e + 36'd8192) >> 14);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // ratio
        r1_s <= i_side;
        r1_r <= n_r;
        // r^2 and linear term
        r2_s  <= r1_s;
        r2_r  <= r1_r;
        r2_rr <= 33'(qmul(33'(r1_r), 33'(r1_r)));
        r2_t  <= 33'(qmul(E_SQ, 33'(r1_r)));
        // cubic weight
        r3_s <= r2_s;
        r3_r <= r2_r;
        r3_t <= r2_t;
        r3_u <= 33'(qmul(E_CUB, r2_rr));
        // quadratic, clamped at zero
        r4_s <= r3_s;
        r4_r <= r3_r;
        r4_q <= (lin_sum > 34'(r3_t)) ? 33'(lin_sum - 34'(r3_t)) : '0;
        // r * q
        r5_s <= r4_s;
        r5_e <= qmul(33'(r4_r), r4_q);
        // round to Q16, saturate, force zero case
        o_zero  <= r5_s.zero;
        o_width <= r5_s.zero ? '0 : r5_s.val;
        if (r5_s.zero) begin
            o_eta <= '0;
        end else if (eta_rnd > 22'(ETA_MAX)) begin
            o_eta <= ETA_MAX;
        end else begin
            o_eta <= eta_rnd[16:0];
        end
    end

    assign o_valid = r_v[5];

endmodule

@@ tb/sv/eta_checker.sv @@
`timescale 1ns / 1ps

module eta_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_lorentz_width,
    input  logic [31:0] i_gauss_width,
    input  logic        o_valid,
    input  logic [16:0] o_mixing_fraction,
    input  logic [32:0] o_combined_width,
    input  logic        o_zero_width,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import pvme_pkg::*;

    typedef struct {
        logic [16:0] eta;
        logic [32:0] width;
        logic        zero;
    } t_voigt;

    t_voigt voigt_q[$];

    // Q30 multiply, half up, wide enough for every operand used here
    function automatic logic [63:0] q30_mul(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = 128'(x) * 128'(y) + 128'(1 << 29);
        return 64'(p >> 30);
    endfunction

    function automatic logic [63:0] fifth_pow(input logic [63:0] y);
        logic [63:0] y2;
        y2 = q30_mul(y, y);
        return q30_mul(q30_mul(y2, y2), y);
    endfunction

    function automatic t_voigt voigt_mix(input logic [31:0] lw, input logic [31:0] gw);
        t_voigt      res;
        logic [63:0] one, s, a, b, a2, a3, a4, a5, b2, b3, b4, b5, poly, y, cand;
        logic [63:0] w, r, q, t, eta;
        one = 64'd1 << 30;
        res.eta = '0; res.width = '0; res.zero = 1'b1;
        if (lw == 0 && gw == 0) return res;
        s = 64'(lw) + 64'(gw);
        a = ((64'(lw) << 30) + (s >> 1)) / s;
        if (a > one) a = one;
        b = one - a;
        a2 = q30_mul(a, a); a3 = q30_mul(a2, a); a4 = q30_mul(a2, a2); a5 = q30_mul(a4, a);
        b2 = q30_mul(b, b); b3 = q30_mul(b2, b); b4 = q30_mul(b2, b2); b5 = q30_mul(b4, b);
        poly = b5 + q30_mul(q30_mul(64'(K_G4L), b4), a)
             + q30_mul(q30_mul(64'(K_G3L2), b3), a2)
             + q30_mul(q30_mul(64'(K_G2L3), b2), a3)
             + q30_mul(q30_mul(64'(K_GL4), b), a4) + a5;
        if (poly > one) poly = one;
        // bitwise search for the fifth root
        y = 0;
        for (int k = 30; k >= 0; k--) begin
            cand = y | (64'd1 << k);
            if (cand <= one && fifth_pow(cand) <= poly) y = cand;
        end
        w = (s * y + (64'd1 << 29)) >> 30;
        if (y == 0) r = 0;
        else begin
            r = (a << 30) / y;
            if (r > 64'(R_MAX)) r = 64'(R_MAX);
        end
        q = 64'(E_LIN) + q30_mul(64'(E_CUB), q30_mul(r, r));
        t = q30_mul(64'(E_SQ), r);
        q = (q > t) ? q - t : 0;
        eta = (q30_mul(r, q) + (64'd1 << 13)) >> 14;
        if (eta > 64'(ETA_MAX)) eta = 64'(ETA_MAX);
        res.eta = eta[16:0]; res.width = w[32:0]; res.zero = 1'b0;
        return res;
    endfunction

    // predict on accepted beats, compare on result strobes
    always @(posedge i_clk) begin
        t_voigt exp_r;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (o_valid) begin
                result_count <= result_count + 1;
                if (voigt_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end else begin
                    exp_r = voigt_q.pop_front();
                    if (o_mixing_fraction !== exp_r.eta) begin
                        $error("mixing_fraction exp %0d got %0d", exp_r.eta, o_mixing_fraction);
                        errs++;
                    end
                    if (o_combined_width !== exp_r.width) begin
                        $error("combined_width exp %0d got %0d", exp_r.width, o_combined_width);
                        errs++;
                    end
                    if (o_zero_width !== exp_r.zero) begin
                        $error("zero_width exp %0d got %0d", exp_r.zero, o_zero_width);
                        errs++;
                    end
                end
            end
            if (start && !busy)
                voigt_q.push_back(voigt_mix(i_lorentz_width, i_gauss_width));
            fail_count <= fail_count + errs;
        end
        pending_count = voigt_q.size();
    end
endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    localparam int LATENCY = 170;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_lorentz_width = '0;
    logic [31:0] i_gauss_width = '0;
    logic        o_valid;
    logic [16:0] o_mixing_fraction;
    logic [32:0] o_combined_width;
    logic        o_zero_width;
    int          fail_count, pending_count, result_count;
    int          idle_cycles = 0;
    int          beats_sent = 0;

    always #1 i_clk = ~i_clk;

    pseudo_voigt_mixing_eta i_dut (.*);

    eta_checker u_check (.*);

    // watchdog: cycles with nothing accepted and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one beat, with a gap drawn from the given idle percentage
    task automatic send_pair(input logic [31:0] lw, input logic [31:0] gw, input int idle_pct);
        while ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_lorentz_width <= lw;
        i_gauss_width <= gw;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_width();
        case ($urandom_range(4, 0))
            0: return $urandom;
            1: return $urandom_range(1000, 0);
            2: return 32'hFFFF_FFFF - $urandom_range(1000, 0);
            3: return 32'd1 << $urandom_range(31, 0);
            default: return $urandom >> $urandom_range(31, 0);
        endcase
    endfunction

    initial begin
        logic [31:0] lw, gw;
        int          waited;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners: both zero, one zero, extremes, equal widths
        send_pair(0, 0, 0);
        send_pair(32'hFFFF_FFFF, 0, 0);
        send_pair(0, 32'hFFFF_FFFF, 0);
        send_pair(1, 0, 0);
        send_pair(0, 1, 0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_pair(1, 1, 0);
        send_pair(1, 32'hFFFF_FFFF, 0);
        send_pair(32'hFFFF_FFFF, 1, 0);
        send_pair(32'h1000_0000, 32'h1000_0000, 0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 0);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_pair(32'h8000_0000, 32'h0000_0001, 0);
        send_pair(32'h0000_0003, 32'h0000_0002, 0);

        // random phases: sender idle 26%, then 87%, then none
        for (int ph = 0; ph < 3; ph++) begin
            for (int n = 0; n < 430; n++) begin
                lw = rand_width();
                gw = rand_width();
                if ($urandom_range(49, 0) == 0) begin
                    lw = 0; gw = 0;
                end
                send_pair(lw, gw, (ph == 0) ? 26 : (ph == 1) ? 87 : 0);
            end
        end
        start <= 1'b0;

        waited = 0;
        while (pending_count != 0 && waited < 10 * LATENCY) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(posedge i_clk);
        $display("sent %0d width pairs (corners, zero pairs, random), %0d results checked",
                 beats_sent, result_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
